>>> rtl/core/png_stream_carver_top_defines.svh
// ----------------------------------------------------------------------------
// PNG stream carver: assertion macros
// Shared concurrent assertion forms for the carver modules.
// ----------------------------------------------------------------------------
`ifndef PNG_STREAM_CARVER_TOP_DEFINES_SVH
`define PNG_STREAM_CARVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psc: next-cycle check failed");

`endif

>>> rtl/core/psc_pkg.sv
// ----------------------------------------------------------------------------
// PNG stream carver package
// Constants, CSR indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Default sizing
   localparam int MAX_NAME_DEF = 32;
   localparam int POS_BITS_DEF = 48;

   // PNG signature, oldest byte in the top byte
   localparam logic [63:0] PNG_SIG   = 64'h8950_4E47_0D0A_1A0A;
   // Chunk type of the closing chunk
   localparam logic [31:0] IEND_TYPE = 32'h4945_4E44;

   // Printable ASCII range
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   // Run length saturation
   localparam logic [8:0] RUN_SAT = 9'd511;

   // CSR indexes
   localparam logic CSR_MIN_NAME_LEN = 1'b0;
   localparam logic CSR_IMAGE_LIMIT  = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;      // input byte transfer
      logic clear;       // byte opens a new blob
      logic search;      // byte goes through the signature window
      logic header;      // byte is a chunk length or type byte
      logic skip;        // byte is payload or CRC
      logic rd;          // read name byte at emit index
      logic load_name;   // load output register with a name byte
      logic load_blank;  // load output register with a nameless result
      logic next_k;      // advance emit index
   } psc_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic match;       // signature completes with this byte
      logic hdr_done;    // last header byte of a chunk
      logic skip_done;   // last skipped byte of a chunk
      logic type_end;    // current chunk is IEND
      logic limit_hit;   // image count reaches the limit with this image
      logic name_empty;  // no name held
      logic name_last;   // emit index is at the last name byte
      logic out_free;    // output register can take a result
   } psc_stat_type;

   // Expected IEND byte for type position i
   function automatic logic [7:0] iend_byte(input logic [1:0] i);
      logic [7:0] b;
      case (i)
         2'd0:    b = IEND_TYPE[31:24];
         2'd1:    b = IEND_TYPE[23:16];
         2'd2:    b = IEND_TYPE[15:8];
         default: b = IEND_TYPE[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/psc_ctrl.sv
// ----------------------------------------------------------------------------
// PNG stream carver controller
// Scan phase and result emission state machine.
// ----------------------------------------------------------------------------
`include "png_stream_carver_top_defines.svh"

module psc_ctrl
   import psc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_first_of_blob,
   input  psc_stat_type stat,
   output psc_cmd_type  cmd
);

   localparam logic [2:0] ST_SEARCH  = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_SKIP    = 3'd2;
   localparam logic [2:0] ST_STOPPED = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;
   localparam logic [2:0] ST_LOAD    = 3'd5;
   localparam logic [2:0] ST_BLANK   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       stop_ff, stop_in;
   logic [2:0] eff_state;
   logic [2:0] resume_state;
   logic       accept;

   // Take bytes only in the scan phases
   assign req_ready    = (state_ff inside {ST_SEARCH, ST_HEADER, ST_SKIP, ST_STOPPED});
   assign accept       = req_valid && req_ready;
   assign eff_state    = req_first_of_blob ? ST_SEARCH : state_ff;
   assign resume_state = stop_ff ? ST_STOPPED : ST_SEARCH;

   // Decode commands and next state
   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      stop_in        = stop_ff;
      cmd.accept     = accept;
      cmd.clear      = accept && req_first_of_blob;
      cmd.search     = accept && (eff_state == ST_SEARCH);
      cmd.header     = accept && (eff_state == ST_HEADER);
      cmd.skip       = accept && (eff_state == ST_SKIP);

      case (state_ff)
         ST_SEARCH, ST_HEADER, ST_SKIP, ST_STOPPED: begin
            if (accept) begin
               state_in = eff_state;
               case (eff_state)
                  ST_SEARCH: begin
                     if (stat.match) state_in = ST_HEADER;
                  end
                  ST_HEADER: begin
                     if (stat.hdr_done) state_in = ST_SKIP;
                  end
                  ST_SKIP: begin
                     if (stat.skip_done) begin
                        if (stat.type_end) begin
                           state_in = stat.name_empty ? ST_BLANK : ST_READ;
                           stop_in  = stat.limit_hit;
                        end else begin
                           state_in = ST_HEADER;
                        end
                     end
                  end
                  default: state_in = eff_state;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.load_name = 1'b1;
               if (stat.name_last) begin
                  state_in = resume_state;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = ST_READ;
               end
            end
         end
         ST_BLANK: begin
            if (stat.out_free) begin
               cmd.load_blank = 1'b1;
               state_in       = resume_state;
            end
         end
         default: state_in = ST_SEARCH;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEARCH;
         stop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         stop_ff  <= stop_in;
      end
   end

   `PSC_ASSERT_NEXT(a_load_waits, clock, reset, (state_ff == ST_LOAD) && !stat.out_free, state_ff == ST_LOAD)
   `PSC_ASSERT_NEXT(a_emit_blocks_input, clock, reset, cmd.skip && stat.skip_done && stat.type_end, !req_ready)
   `PSC_ASSERT_IMPL(a_one_phase, clock, reset, cmd.accept, $onehot({cmd.search, cmd.header, cmd.skip}) || (state_ff == ST_STOPPED))

endmodule

>>> rtl/core/psc_datapath.sv
// ----------------------------------------------------------------------------
// PNG stream carver datapath
// Signature window, name tracking, chunk walk, name memory and output register.
// ----------------------------------------------------------------------------
`include "png_stream_carver_top_defines.svh"

module psc_datapath
   import psc_pkg::*;
#(
   parameter int MAX_NAME = MAX_NAME_DEF,
   parameter int POS_BITS = POS_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic [7:0]          req_byte_value,
   input  psc_cmd_type         cmd,
   output psc_stat_type        stat,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [POS_BITS-1:0] rsp_image_offset,
   output logic [POS_BITS-1:0] rsp_image_length,
   output logic [6:0]          rsp_name_char,
   output logic                rsp_name_present,
   output logic                rsp_name_cut,
   output logic                rsp_final_item
);

   localparam int IDX_W     = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
   localparam int CNT_W     = $clog2(MAX_NAME + 1);
   localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

   // Configuration
   logic [7:0]  min_len_ff;
   logic [15:0] limit_ff;

   // Scan state
   logic [63:0]         window_ff, window_in;
   logic [3:0]          wfill_ff, wfill_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [2:0]          hbc_ff, hbc_in;
   logic [31:0]         acc_ff, acc_in;
   logic                tie_ff, tie_in;
   logic [32:0]         skip_ff, skip_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [8:0]          run_count_ff, run_count_in;
   logic [8:0]          name_count_ff, name_count_in;
   logic                run_bank_ff, run_bank_in;
   logic [15:0]         found_ff, found_in;

   // Emission state
   logic [POS_BITS-1:0] em_off_ff, em_off_in;
   logic [POS_BITS-1:0] em_len_ff, em_len_in;
   logic [CNT_W-1:0]    em_n_ff, em_n_in;
   logic                em_cut_ff, em_cut_in;
   logic [IDX_W-1:0]    k_ff, k_in;

   // Output register
   logic                rsp_valid_ff;
   logic [POS_BITS-1:0] out_off_ff, out_len_ff;
   logic [6:0]          out_char_ff;
   logic                out_present_ff, out_cut_ff, out_final_ff;

   // Name memory: two banks, one collects the current run, the other holds the name
   logic [6:0]       name_mem [MEM_DEPTH];
   logic [6:0]       rdata_ff;
   logic             mem_we;
   logic [IDX_W:0]   mem_waddr;
   logic [6:0]       mem_wdata;

   // Effective values after a blob restart
   logic [63:0]         window_e;
   logic [3:0]          wfill_e;
   logic [POS_BITS-1:0] pos_e;
   logic [8:0]          run_count_e, name_count_e;
   logic [15:0]         found_e;
   logic [63:0]         window_n;
   logic [3:0]          wfill_n;
   logic [7:0]          oldest;
   logic                printable;
   logic [15:0]         found_inc;
   logic [32:0]         skip_n;
   logic                tie_n;

   assign window_e     = cmd.clear ? '0 : window_ff;
   assign wfill_e      = cmd.clear ? '0 : wfill_ff;
   assign pos_e        = cmd.clear ? '0 : pos_ff;
   assign run_count_e  = cmd.clear ? '0 : run_count_ff;
   assign name_count_e = cmd.clear ? '0 : name_count_ff;
   assign found_e      = cmd.clear ? '0 : found_ff;

   assign window_n  = {window_e[55:0], req_byte_value};
   assign wfill_n   = wfill_e[3] ? wfill_e : wfill_e + 4'd1;
   assign oldest    = window_e[63:56];
   assign printable = (oldest inside {[PRINT_LO:PRINT_HI]});
   assign found_inc = (found_ff == 16'hFFFF) ? found_ff : found_ff + 16'd1;
   assign skip_n    = (skip_ff != '0) ? skip_ff - 33'd1 : skip_ff;
   assign tie_n     = ((hbc_ff == 3'd4) ? 1'b1 : tie_ff)
                      && (req_byte_value == iend_byte(hbc_ff[1:0]));

   // Status toward the controller
   always_comb begin
      stat            = '0;
      stat.match      = wfill_n[3] && (window_n == PNG_SIG);
      stat.hdr_done   = (hbc_ff == 3'd7);
      stat.skip_done  = (skip_ff <= 33'd1);
      stat.type_end   = tie_ff;
      stat.limit_hit  = (limit_ff != '0) && (found_inc >= limit_ff);
      stat.name_empty = (name_count_ff == '0);
      stat.name_last  = ((CNT_W'(k_ff) + CNT_W'(1)) == em_n_ff);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Next scan state for an accepted byte
   always_comb begin
      window_in     = window_ff;
      wfill_in      = wfill_ff;
      pos_in        = pos_ff;
      hbc_in        = hbc_ff;
      acc_in        = acc_ff;
      tie_in        = tie_ff;
      skip_in       = skip_ff;
      start_in      = start_ff;
      run_count_in  = run_count_ff;
      name_count_in = name_count_ff;
      run_bank_in   = run_bank_ff;
      found_in      = found_ff;
      em_off_in     = em_off_ff;
      em_len_in     = em_len_ff;
      em_n_in       = em_n_ff;
      em_cut_in     = em_cut_ff;
      k_in          = k_ff;
      mem_we        = 1'b0;
      mem_waddr     = {run_bank_ff, run_count_ff[IDX_W-1:0]};
      mem_wdata     = oldest[6:0];

      if (cmd.accept) begin
         pos_in        = pos_e + POS_BITS'(1);
         window_in     = window_e;
         wfill_in      = wfill_e;
         run_count_in  = run_count_e;
         name_count_in = name_count_e;
         found_in      = found_e;
         if (cmd.clear) begin
            hbc_in   = '0;
            acc_in   = '0;
            tie_in   = 1'b0;
            skip_in  = '0;
            start_in = '0;
         end
      end

      // Slide window, track the byte leaving it
      if (cmd.search) begin
         window_in = window_n;
         wfill_in  = wfill_n;
         if (wfill_e[3]) begin
            if (printable) begin
               mem_we = (run_count_e < 9'(MAX_NAME));
               if (run_count_e < RUN_SAT) run_count_in = run_count_e + 9'd1;
            end else begin
               if (run_count_e >= {1'b0, min_len_ff}) begin
                  name_count_in = run_count_e;
                  run_bank_in   = ~run_bank_ff;
               end
               run_count_in = '0;
            end
         end
         if (stat.match) begin
            if (run_count_in >= {1'b0, min_len_ff}) begin
               name_count_in = run_count_in;
               run_bank_in   = ~run_bank_in;
            end
            run_count_in = '0;
            start_in     = pos_e - POS_BITS'(7);
            hbc_in       = '0;
            acc_in       = '0;
            tie_in       = 1'b0;
         end
      end

      // Collect chunk length and type
      if (cmd.header) begin
         if (!hbc_ff[2]) acc_in = {acc_ff[23:0], req_byte_value};
         else            tie_in = tie_n;
         if (stat.hdr_done) begin
            skip_in = {1'b0, acc_ff} + 33'd4;
            hbc_in  = '0;
         end else begin
            hbc_in = hbc_ff + 3'd1;
         end
      end

      // Skip payload and CRC; close the image at the end of IEND
      if (cmd.skip) begin
         skip_in = skip_n;
         if (stat.skip_done) begin
            if (tie_ff) begin
               em_off_in     = start_ff;
               em_len_in     = pos_ff + POS_BITS'(1) - start_ff;
               em_n_in       = (name_count_ff < 9'(MAX_NAME)) ? CNT_W'(name_count_ff)
                                                              : CNT_W'(MAX_NAME);
               em_cut_in     = (name_count_ff > 9'(MAX_NAME));
               k_in          = '0;
               found_in      = found_inc;
               window_in     = '0;
               wfill_in      = '0;
               run_count_in  = '0;
               name_count_in = '0;
               tie_in        = 1'b0;
               acc_in        = '0;
            end else begin
               acc_in = '0;
               hbc_in = '0;
            end
         end
      end

      // Advance emit index
      if (cmd.next_k) k_in = k_ff + IDX_W'(1);
   end

   // Hold configuration and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff    <= 8'd4;
         limit_ff      <= '0;
         window_ff     <= '0;
         wfill_ff      <= '0;
         pos_ff        <= '0;
         hbc_ff        <= '0;
         acc_ff        <= '0;
         tie_ff        <= 1'b0;
         skip_ff       <= '0;
         start_ff      <= '0;
         run_count_ff  <= '0;
         name_count_ff <= '0;
         run_bank_ff   <= 1'b0;
         found_ff      <= '0;
         em_n_ff       <= '0;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_NAME_LEN: min_len_ff <= csr_wdata[7:0];
               CSR_IMAGE_LIMIT:  limit_ff   <= csr_wdata;
               default:          limit_ff   <= limit_ff;
            endcase
         end
         window_ff     <= window_in;
         wfill_ff      <= wfill_in;
         pos_ff        <= pos_in;
         hbc_ff        <= hbc_in;
         acc_ff        <= acc_in;
         tie_ff        <= tie_in;
         skip_ff       <= skip_in;
         start_ff      <= start_in;
         run_count_ff  <= run_count_in;
         name_count_ff <= name_count_in;
         run_bank_ff   <= run_bank_in;
         found_ff      <= found_in;
         em_n_ff       <= em_n_in;
         k_ff          <= k_in;
         if (cmd.load_name || cmd.load_blank) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                  rsp_valid_ff <= 1'b0;
      end
   end

   // Emission payload and output register
   always_ff @(posedge clock) begin
      em_off_ff <= em_off_in;
      em_len_ff <= em_len_in;
      em_cut_ff <= em_cut_in;
      if (cmd.load_name || cmd.load_blank) begin
         out_off_ff     <= em_off_ff;
         out_len_ff     <= em_len_ff;
         out_cut_ff     <= em_cut_ff;
         out_char_ff    <= cmd.load_name ? rdata_ff : 7'd0;
         out_present_ff <= cmd.load_name;
         out_final_ff   <= cmd.load_blank || stat.name_last;
      end
   end

   // Name memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) name_mem[mem_waddr] <= mem_wdata;
      if (cmd.rd) rdata_ff <= name_mem[{~run_bank_ff, k_ff}];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_image_offset = out_off_ff;
   assign rsp_image_length = out_len_ff;
   assign rsp_name_char    = out_char_ff;
   assign rsp_name_present = out_present_ff;
   assign rsp_name_cut     = out_cut_ff;
   assign rsp_final_item   = out_final_ff;

   `PSC_ASSERT_IMPL(a_name_index, clock, reset, cmd.load_name, (em_n_ff != '0) && (CNT_W'(k_ff) < em_n_ff))
   `PSC_ASSERT_IMPL(a_fill_range, clock, reset, 1'b1, wfill_ff <= 4'd8)
   `PSC_ASSERT_NEXT(a_emit_drops_name, clock, reset, cmd.skip && stat.skip_done && tie_ff, (name_count_ff == '0) && (run_count_ff == '0))

endmodule

>>> rtl/core/png_stream_carver_top.sv
// ----------------------------------------------------------------------------
// PNG stream carver top level
// Finds complete PNG images in a byte stream and reports offset, length and
// the printable name run seen before each image, one result per name byte.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_byte_value, req_first_of_blob
//   rsp      out  rsp_valid/rsp_ready  offset, length, name_char, flags
//   csr      in   csr_wr_en            csr_index, csr_wdata
//
// One byte per cycle while scanning the signature and the chunk table.
// When an IEND chunk closes, input pauses while each name byte passes a name
// memory read and then an output register load, or while a blank result loads.
// A stalled rsp_ready stretches that pause; the last result may still wait
// while the next bytes are taken. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module png_stream_carver_top
   import psc_pkg::*;
#(
   parameter int MAX_NAME = MAX_NAME_DEF,
   parameter int POS_BITS = POS_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_value,
   input  logic                req_first_of_blob,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_BITS-1:0] rsp_image_offset,
   output logic [POS_BITS-1:0] rsp_image_length,
   output logic [6:0]          rsp_name_char,
   output logic                rsp_name_present,
   output logic                rsp_name_cut,
   output logic                rsp_final_item,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);

   psc_cmd_type  cmd;
   psc_stat_type stat;

   // Phase and emission sequencing
   psc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_of_blob (req_first_of_blob),
      .stat              (stat),
      .cmd               (cmd)
   );

   // Window, chunk walk, name memory and output register
   psc_datapath #(
      .MAX_NAME (MAX_NAME),
      .POS_BITS (POS_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_byte_value   (req_byte_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_image_offset (rsp_image_offset),
      .rsp_image_length (rsp_image_length),
      .rsp_name_char    (rsp_name_char),
      .rsp_name_present (rsp_name_present),
      .rsp_name_cut     (rsp_name_cut),
      .rsp_final_item   (rsp_final_item)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// PNG stream carver testbench
// Feeds blobs of names, PNG signatures and chunk tables into the carver. A
// scoreboard tracks the scan itself and checks each carved record in order,
// one per name byte. Configuration and idling change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
   import psc_pkg::*;

   localparam int NAME_CAP      = MAX_NAME_DEF;
   localparam int POS_W         = POS_BITS_DEF;
   localparam int CLK_PERIOD    = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES        = 3;

   typedef enum logic [1:0] {SEEKING, IN_HEADER, SKIPPING, HALTED} scan_state_type;

   typedef struct packed {
      logic [POS_W-1:0] offset;
      logic [POS_W-1:0] length;
      logic [6:0]       ch;
      logic             present;
      logic             cut;
      logic             last;
   } carve_rec_type;

   // Scan tracker and queue of carved records still to arrive
   class carve_scoreboard;
      logic [7:0]       min_len;
      logic [15:0]      img_limit;
      logic [63:0]      window;
      int               fill;
      logic [POS_W-1:0] pos;
      scan_state_type   state;
      int               hdr_idx;
      logic [31:0]      chunk_len;
      bit               is_iend;
      logic [32:0]      skip_left;
      logic [POS_W-1:0] img_start;
      logic [6:0]       run_buf [NAME_CAP];
      logic [8:0]       run_len;
      logic [6:0]       name_buf [NAME_CAP];
      logic [8:0]       name_len;
      logic [15:0]      found;
      carve_rec_type    carve_q [$];
      int               errors;

      function new();
         min_len = 8'd4;
         img_limit = 16'd0;
         errors = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         window = '0;
         fill = 0;
         pos = '0;
         state = SEEKING;
         hdr_idx = 0;
         chunk_len = '0;
         is_iend = 0;
         skip_left = '0;
         img_start = '0;
         run_len = '0;
         name_len = '0;
         found = '0;
      endfunction

      function void set_register(logic idx, logic [15:0] data);
         if (idx == CSR_MIN_NAME_LEN) begin
            min_len = data[7:0];
         end else begin
            img_limit = data;
         end
      endfunction

      // Promote the current printable run to the held name if long enough
      function void close_name_run();
         int keep;
         if (run_len >= min_len) begin
            keep = (run_len < NAME_CAP) ? run_len : NAME_CAP;
            for (int k = 0; k < keep; k++) name_buf[k] = run_buf[k];
            name_len = run_len;
         end
      endfunction

      function void track_name_run(logic [7:0] b);
         if (b >= PRINT_LO && b <= PRINT_HI) begin
            if (run_len < NAME_CAP) run_buf[run_len] = b[6:0];
            if (run_len < RUN_SAT) run_len++;
         end else begin
            close_name_run();
            run_len = '0;
         end
      endfunction

      function void emit_image_records();
         carve_rec_type rec;
         int n;
         n = (name_len < NAME_CAP) ? name_len : NAME_CAP;
         rec.offset = img_start;
         rec.length = pos + 1 - img_start;
         rec.cut = (name_len > NAME_CAP);
         if (n == 0) begin
            rec.ch = '0;
            rec.present = 1'b0;
            rec.last = 1'b1;
            carve_q.insert(carve_q.size(), rec);
         end else begin
            for (int k = 0; k < n; k++) begin
               rec.ch = name_buf[k];
               rec.present = 1'b1;
               rec.last = (k == n - 1);
               carve_q.insert(carve_q.size(), rec);
            end
         end
      endfunction

      // Advance the scan by one accepted byte
      function void note_byte(logic [7:0] b, logic first);
         if (first) clear_scan();
         case (state)
            SEEKING: begin
               if (fill >= 8) track_name_run(window[63:56]);
               else fill++;
               window = {window[55:0], b};
               if (fill >= 8 && window == PNG_SIG) begin
                  close_name_run();
                  run_len = '0;
                  img_start = pos - 7;
                  state = IN_HEADER;
                  hdr_idx = 0;
                  chunk_len = '0;
                  is_iend = 0;
               end
            end
            IN_HEADER: begin
               if (hdr_idx < 4) begin
                  chunk_len = {chunk_len[23:0], b};
               end else begin
                  if (hdr_idx == 4) is_iend = 1;
                  if (b != IEND_TYPE[31 - 8 * (hdr_idx - 4) -: 8]) is_iend = 0;
               end
               if (hdr_idx >= 7) begin
                  skip_left = {1'b0, chunk_len} + 33'd4;
                  hdr_idx = 0;
                  state = SKIPPING;
               end else begin
                  hdr_idx++;
               end
            end
            SKIPPING: begin
               if (skip_left != 0) skip_left--;
               if (skip_left == 0) begin
                  if (is_iend) begin
                     emit_image_records();
                     if (found != 16'hFFFF) found++;
                     window = '0;
                     fill = 0;
                     run_len = '0;
                     name_len = '0;
                     is_iend = 0;
                     chunk_len = '0;
                     state = (img_limit != 0 && found >= img_limit) ? HALTED : SEEKING;
                  end else begin
                     chunk_len = '0;
                     hdr_idx = 0;
                     state = IN_HEADER;
                  end
               end
            end
            default: ;
         endcase
         pos++;
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_result(carve_rec_type got);
         carve_rec_type want;
         if (carve_q.size() == 0) begin
            report($sformatf("result with none pending, offset %0d", got.offset));
            return;
         end
         want = carve_q.pop_front();
         if (got.offset != want.offset)
            report($sformatf("image_offset %0d, want %0d", got.offset, want.offset));
         if (got.length != want.length)
            report($sformatf("image_length %0d, want %0d", got.length, want.length));
         if (got.ch != want.ch)
            report($sformatf("name_char %h, want %h", got.ch, want.ch));
         if (got.present != want.present)
            report($sformatf("name_present %0d, want %0d", got.present, want.present));
         if (got.cut != want.cut)
            report($sformatf("name_cut %0d, want %0d", got.cut, want.cut));
         if (got.last != want.last)
            report($sformatf("final_item %0d, want %0d", got.last, want.last));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_byte_value = 8'h00;
   logic                req_first_of_blob = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [POS_W-1:0]    rsp_image_offset;
   logic [POS_W-1:0]    rsp_image_length;
   logic [6:0]          rsp_name_char;
   logic                rsp_name_present;
   logic                rsp_name_cut;
   logic                rsp_final_item;
   logic                csr_wr_en = 1'b0;
   logic                csr_index = 1'b0;
   logic [15:0]         csr_wdata = 16'h0000;

   carve_scoreboard sb = new();
   bit              new_blob = 1'b0;
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              phase_bytes = 0;
   int              cycle_count = 0;

   logic [7:0]  min_tab [PHASES] = '{8'd3, 8'd1, 8'd0};
   logic [15:0] limit_tab [PHASES] = '{16'd0, 16'd65535, 16'd2};

   png_stream_carver_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_value    (req_byte_value),
      .req_first_of_blob (req_first_of_blob),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_image_offset  (rsp_image_offset),
      .rsp_image_length  (rsp_image_length),
      .rsp_name_char     (rsp_name_char),
      .rsp_name_present  (rsp_name_present),
      .rsp_name_cut      (rsp_name_cut),
      .rsp_final_item    (rsp_final_item),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Feed accepted bytes to the scoreboard, then check accepted results
   always @(posedge clock) begin : watch
      carve_rec_type got;
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_byte_value, req_first_of_blob);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_image_offset, rsp_image_length, rsp_name_char,
                   rsp_name_present, rsp_name_cut, rsp_final_item};
            sb.check_result(got);
         end
      end
   end

   // Hard stop for a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic set_idle(input int mode);
      case (mode)
         0:       begin idle_pct = 0;  stall_pct = 0;  end
         1:       begin idle_pct = 77; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 77; end
         default: begin idle_pct = 17; stall_pct = 17; end
      endcase
   endtask

   task automatic start_blob();
      new_blob = 1'b1;
   endtask

   // Hold one byte until its transfer, then maybe drop valid for a while
   task automatic put_byte(input logic [7:0] b);
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_first_of_blob <= new_blob;
      new_blob = 1'b0;
      do @(posedge clock); while (!req_ready);
      phase_bytes++;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_noise(input int n);
      repeat (n) put_byte(8'($urandom_range(255, 0)));
   endtask

   task automatic put_printable(input int n);
      repeat (n) put_byte(8'($urandom_range(126, 32)));
   endtask

   function automatic logic [7:0] nonprint_byte();
      logic [7:0] b;
      case ($urandom_range(2, 0))
         0:       b = 8'($urandom_range(31, 0));
         1:       b = 8'h7F;
         default: b = 8'($urandom_range(255, 128));
      endcase
      return b;
   endfunction

   task automatic put_signature(input bit corrupt);
      logic [7:0] b;
      int bad;
      bad = corrupt ? $urandom_range(7, 0) : -1;
      for (int i = 0; i < 8; i++) begin
         b = PNG_SIG[63 - 8 * i -: 8];
         if (i == bad) b = b ^ 8'($urandom_range(255, 1));
         put_byte(b);
      end
   endtask

   task automatic put_header(input logic [31:0] len, input logic [31:0] kind);
      for (int i = 3; i >= 0; i--) put_byte(len[8 * i +: 8]);
      for (int i = 3; i >= 0; i--) put_byte(kind[8 * i +: 8]);
   endtask

   task automatic put_chunk(input int len, input logic [31:0] kind);
      put_header(len, kind);
      put_noise(len + 4);
   endtask

   // One image with a random name, extra chunks, and sometimes a cut-off table
   task automatic put_random_image(output bit cut_short);
      logic [31:0] kind;
      int run_sel;
      cut_short = 1'b0;
      put_noise($urandom_range(3, 0));
      if ($urandom_range(99) < 75) begin
         put_byte(nonprint_byte());
         run_sel = $urandom_range(99);
         if (run_sel < 60) put_printable($urandom_range(8, 0));
         else if (run_sel < 85) put_printable($urandom_range(31, 9));
         else put_printable($urandom_range(45, 32));
      end
      put_signature($urandom_range(99) < 8);
      repeat ($urandom_range(2, 0)) begin
         if ($urandom_range(99) < 30) kind = IEND_TYPE ^ (32'h1 << $urandom_range(31, 0));
         else kind = $urandom;
         if (kind == IEND_TYPE) kind = kind ^ 32'h8000_0000;
         put_chunk($urandom_range(6, 0), kind);
      end
      if ($urandom_range(99) < 10) begin
         cut_short = 1'b1;
         if ($urandom_range(1, 0) == 1) begin
            put_noise($urandom_range(7, 0));
         end else begin
            put_header($urandom | 32'h0100_0000,
                       ($urandom_range(1, 0) == 1) ? IEND_TYPE : $urandom);
            put_noise($urandom_range(6, 0));
         end
      end else begin
         put_chunk(($urandom_range(99) < 80) ? 0 : $urandom_range(3, 1), IEND_TYPE);
      end
   endtask

   // Drop valid and wait until every pending record has arrived
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.carve_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges
   task automatic set_registers(input logic [7:0] min_len, input logic [15:0] lim);
      logic [15:0] min_word;
      min_word = {8'($urandom_range(255, 0)), min_len};
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MIN_NAME_LEN;
      csr_wdata <= min_word;
      sb.set_register(CSR_MIN_NAME_LEN, min_word);
      @(posedge clock);
      csr_index <= CSR_IMAGE_LIMIT;
      csr_wdata <= lim;
      sb.set_register(CSR_IMAGE_LIMIT, lim);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : run
      bit cut_short;
      int img_count;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_idle(0);

      // Name at the printable boundaries, just long enough
      start_blob();
      put_byte(8'h1F);
      put_text(" ~Az");
      put_signature(1'b0);
      put_chunk(0, IEND_TYPE);
      // Short run ended by DEL, regular chunk and a near-miss type: nameless image
      put_text("ab");
      put_byte(8'h7F);
      put_signature(1'b0);
      put_chunk(3, 32'h4948_4452);
      put_chunk(0, IEND_TYPE ^ 32'h1);
      put_chunk(1, IEND_TYPE);
      // Name longer than the store
      put_byte(8'hFF);
      put_printable(40);
      put_signature(1'b0);
      put_chunk(0, IEND_TYPE);
      // Truncated image: huge chunk length, then a new blob
      put_signature(1'b0);
      put_header(32'hFFFF_FFFF, 32'h4944_4154);
      put_noise(3);

      // Zero minimum: the empty run at the signature replaces the name
      settle();
      set_registers(8'd0, 16'd0);
      start_blob();
      put_text("abcd");
      put_byte(8'h00);
      put_signature(1'b0);
      put_chunk(0, IEND_TYPE);

      // Limit of one: second image in the blob is ignored until a new blob
      settle();
      set_registers(8'd4, 16'd1);
      start_blob();
      put_text("first");
      put_signature(1'b0);
      put_chunk(0, IEND_TYPE);
      put_text("second");
      put_signature(1'b0);
      put_chunk(0, IEND_TYPE);
      start_blob();
      put_text("third");
      put_signature(1'b0);
      put_chunk(2, IEND_TYPE);

      // Random phases, each with its own settings and idling
      for (int p = 0; p < PHASES; p++) begin
         settle();
         set_registers(min_tab[p], limit_tab[p]);
         set_idle(p + 1);
         start_blob();
         phase_bytes = 0;
         img_count = 0;
         while (phase_bytes < 16 && img_count < 2) begin
            if ($urandom_range(99) < 10) put_noise($urandom_range(30, 5));
            put_random_image(cut_short);
            img_count++;
            if (cut_short || $urandom_range(99) < 30) start_blob();
         end
      end

      settle();
      if (sb.errors == 0 && sb.carve_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
